// ----- rtl/detection_persistence_filter_unit_assert.svh -----
// Assertion macros for the detection persistence filter.
`ifndef DETECTION_PERSISTENCE_FILTER_UNIT_ASSERT_SVH
`define DETECTION_PERSISTENCE_FILTER_UNIT_ASSERT_SVH

// Condition holds in the same cycle.
`define DPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the following cycle.
`define DPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dpf_pkg.sv -----
// Shared widths, codes and types of the detection persistence filter.
`default_nettype none
package dpf_pkg;

  localparam int BOX_W      = 11;
  localparam int COORD_W    = 12;
  localparam int CNT_W      = 4;
  localparam int R2_W       = 24;
  localparam int PERIOD_W   = 8;
  localparam int THR_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic OP_BOX = 1'b0;
  localparam logic OP_EOF = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_THR   = 2'd2;

  localparam logic [COORD_W-1:0]  RADIUS_RST = 12'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd8;
  localparam logic [THR_W-1:0]    THR_RST    = 3'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CNT_W-1:0]   count;
  } dpf_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MATCH,
    ST_INSERT,
    ST_BEST,
    ST_DECAY,
    ST_DONE
  } dpf_state_t;

endpackage
`default_nettype wire

// ----- rtl/dpf_if.sv -----
// Channel interfaces: detection input, result output and register write.
`default_nettype none
interface dpf_in_if;
  import dpf_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [BOX_W-1:0] box_x;
  logic [BOX_W-1:0] box_y;
  logic [BOX_W-1:0] box_w;
  logic [BOX_W-1:0] box_h;
  modport source (output valid, op, box_x, box_y, box_w, box_h, input ready);
  modport sink   (input valid, op, box_x, box_y, box_w, box_h, output ready);
endinterface

interface dpf_out_if;
  import dpf_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] best_x;
  logic [COORD_W-1:0] best_y;
  logic               confirmed;
  logic               table_full;
  modport source (output valid, best_x, best_y, confirmed, table_full, input ready);
  modport sink   (input valid, best_x, best_y, confirmed, table_full, output ready);
endinterface

interface dpf_cfg_if;
  import dpf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/detection_persistence_filter_unit.sv -----
// Detection persistence filter top level: point table in one RAM, scanned per item.
// Box item: match scan, write and best scan over the N stored points.
// Frame end: frame counter step, or a decay pass once the counter reaches the period.
// One item in flight; the next transfer can be taken in the cycle after the result is loaded.
// Reset (rst_n low, synchronous): table empty, counters and held point zero, registers
// back to radius 100, period 8, threshold 3. RAM contents are not cleared.
`default_nettype none
module detection_persistence_filter_unit #(
  parameter int MAX_POINTS  = 16,
  parameter int COUNT_LIMIT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  dpf_in_if.sink    in_bus,
  dpf_out_if.source out_bus,
  dpf_cfg_if.sink   cfg_bus
);
  import dpf_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int UW    = $clog2(MAX_POINTS + 1);

  // FSM and configuration
  dpf_state_t          state_r, state_nxt;
  logic [COORD_W-1:0]  radius_r, radius_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;

  // architectural state outside the RAM
  logic [UW-1:0]       used_r, used_nxt;
  logic [PERIOD_W-1:0] fc_r, fc_nxt;
  logic [COORD_W-1:0]  held_x_r, held_x_nxt;
  logic [COORD_W-1:0]  held_y_r, held_y_nxt;
  logic                held_c_r, held_c_nxt;

  // per-item working registers
  logic                full_r, full_nxt;
  logic [COORD_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [R2_W-1:0]     r2_r, r2_nxt;
  logic [UW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [UW-1:0]       wr_idx_r, wr_idx_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [CNT_W-1:0]    hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]    best_cnt_r, best_cnt_nxt;
  logic [COORD_W-1:0]  best_x_r, best_x_nxt, best_y_r, best_y_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                out_c_r, out_c_nxt, out_f_r, out_f_nxt;

  // point table RAM, one write and one registered read port
  dpf_entry_t          mem [MAX_POINTS];
  dpf_entry_t          mem_q_r;
  logic                rv_r;
  logic [IDX_W-1:0]    ri_r;
  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  dpf_entry_t          wr_data;

  // match unit outputs
  logic                m_valid, m_hit, m_busy;
  logic [IDX_W-1:0]    m_idx;
  dpf_entry_t          m_entry;

  logic [PERIOD_W-1:0] fc_inc;
  logic [CNT_W-1:0]    inc_cnt;
  logic [CNT_W-1:0]    dec_cnt;

  // assertion helpers
  logic                in_xfer;
  logic                decay_rw;

  assign fc_inc  = fc_r + PERIOD_W'(1);
  // count saturates at the limit
  assign inc_cnt = (hit_cnt_r < CNT_W'(COUNT_LIMIT)) ? hit_cnt_r + CNT_W'(1)
                                                     : CNT_W'(COUNT_LIMIT);
  assign dec_cnt = (mem_q_r.count == '0) ? '0 : mem_q_r.count - CNT_W'(1);

  assign in_bus.ready       = (state_r == ST_IDLE);
  assign cfg_bus.ready      = 1'b1;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.best_x     = out_x_r;
  assign out_bus.best_y     = out_y_r;
  assign out_bus.confirmed  = out_c_r;
  assign out_bus.table_full = out_f_r;

  dpf_match #(.IDX_W(IDX_W)) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rv_r && (state_r == ST_MATCH)),
    .in_idx    (ri_r),
    .in_entry  (mem_q_r),
    .cx        (cx_r),
    .cy        (cy_r),
    .r2        (r2_r),
    .out_valid (m_valid),
    .out_idx   (m_idx),
    .out_hit   (m_hit),
    .out_entry (m_entry),
    .busy      (m_busy)
  );

  always_comb begin
    state_nxt     = state_r;
    radius_nxt    = radius_r;
    period_nxt    = period_r;
    thr_nxt       = thr_r;
    used_nxt      = used_r;
    fc_nxt        = fc_r;
    held_x_nxt    = held_x_r;
    held_y_nxt    = held_y_r;
    held_c_nxt    = held_c_r;
    full_nxt      = full_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    r2_nxt        = r2_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    best_cnt_nxt  = best_cnt_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_c_nxt     = out_c_r;
    out_f_nxt     = out_f_r;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    // register writes are to arrive only while idle; the block itself does not enforce it
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_MATCH_RADIUS: radius_nxt = cfg_bus.data;
        CFG_DECAY_PERIOD: period_nxt = cfg_bus.data[PERIOD_W-1:0];
        CFG_CONFIRM_THR:  thr_nxt    = cfg_bus.data[THR_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_bus.valid) begin
          full_nxt = 1'b0;
          if (in_bus.op == OP_BOX) begin
            // box center, halves rounded down
            cx_nxt    = COORD_W'(in_bus.box_x) + COORD_W'(in_bus.box_w >> 1);
            cy_nxt    = COORD_W'(in_bus.box_y) + COORD_W'(in_bus.box_h >> 1);
            state_nxt = ST_PREP;
          end else if (fc_inc >= period_r) begin
            fc_nxt     = '0;
            rd_idx_nxt = '0;
            wr_idx_nxt = '0;
            state_nxt  = ST_DECAY;
          end else begin
            fc_nxt    = fc_inc;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PREP: begin
        r2_nxt     = R2_W'(radius_r) * R2_W'(radius_r);
        rd_idx_nxt = '0;
        found_nxt  = 1'b0;
        state_nxt  = ST_MATCH;
      end
      ST_MATCH: begin
        // results return in table order, so the first hit is the lowest index
        if (m_valid && m_hit) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = m_idx;
          hit_cnt_nxt = m_entry.count;
          state_nxt   = ST_INSERT;
        end else if (rd_idx_r < used_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + UW'(1);
        end else if (!rv_r && !m_busy) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = hit_idx_r;
          wr_data = '{x: cx_r, y: cy_r, count: inc_cnt};
        end else if (used_r < UW'(MAX_POINTS)) begin
          wr_en    = 1'b1;
          wr_addr  = used_r[IDX_W-1:0];
          wr_data  = '{x: cx_r, y: cy_r, count: CNT_W'(1)};
          used_nxt = used_r + UW'(1);
        end else begin
          full_nxt = 1'b1;
        end
        rd_idx_nxt   = '0;
        best_cnt_nxt = '0;
        best_x_nxt   = '0;
        best_y_nxt   = '0;
        state_nxt    = ST_BEST;
      end
      ST_BEST: begin
        // strict compare keeps the lowest index among equal counts
        if (rv_r && (mem_q_r.count > best_cnt_r)) begin
          best_cnt_nxt = mem_q_r.count;
          best_x_nxt   = mem_q_r.x;
          best_y_nxt   = mem_q_r.y;
        end
        if (rd_idx_r < used_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + UW'(1);
        end else if (!rv_r) begin
          if (best_cnt_r > CNT_W'(thr_r)) begin
            held_x_nxt = best_x_r;
            held_y_nxt = best_y_r;
            held_c_nxt = 1'b1;
          end else begin
            held_x_nxt = '0;
            held_y_nxt = '0;
            held_c_nxt = 1'b0;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DECAY: begin
        // compaction: the write pointer trails the read pointer
        if (rv_r && (dec_cnt != '0)) begin
          wr_en      = 1'b1;
          wr_addr    = wr_idx_r[IDX_W-1:0];
          wr_data    = '{x: mem_q_r.x, y: mem_q_r.y, count: dec_cnt};
          wr_idx_nxt = wr_idx_r + UW'(1);
        end
        if (rd_idx_r < used_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + UW'(1);
        end else if (!rv_r) begin
          used_nxt  = wr_idx_r;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = held_x_r;
          out_y_nxt     = held_y_r;
          out_c_nxt     = held_c_r;
          out_f_nxt     = full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= RADIUS_RST;
      period_r    <= PERIOD_RST;
      thr_r       <= THR_RST;
      used_r      <= '0;
      fc_r        <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_c_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      period_r    <= period_nxt;
      thr_r       <= thr_nxt;
      used_r      <= used_nxt;
      fc_r        <= fc_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
      held_c_r    <= held_c_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rd_en;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    full_r     <= full_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    r2_r       <= r2_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    found_r    <= found_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_x_r   <= best_x_nxt;
    best_y_r   <= best_y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_c_r    <= out_c_nxt;
    out_f_r    <= out_f_nxt;
    ri_r       <= rd_addr;
  end

  // table RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign in_xfer  = in_bus.valid && in_bus.ready;
  assign decay_rw = (state_r == ST_DECAY) && wr_en && rd_en;

  `include "detection_persistence_filter_unit_assert.svh"

  `DPF_ASSERT_NOW(a_used_bound, 1'b1, used_r <= UW'(MAX_POINTS), "point count beyond table depth")
  `DPF_ASSERT_NOW(a_decay_order, decay_rw, wr_addr < rd_addr, "compaction write overtook read")
  `DPF_ASSERT_NEXT(a_accept_busy, in_xfer, state_r != ST_IDLE, "idle after transfer")

endmodule
`default_nettype wire

// ----- rtl/dpf_match.sv -----
// Three-stage squared-distance compare of a stored point against a center.
`default_nettype none
module dpf_match #(
  parameter int IDX_W = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [IDX_W-1:0]           in_idx,
  input  dpf_pkg::dpf_entry_t        in_entry,
  input  logic [dpf_pkg::COORD_W-1:0] cx,
  input  logic [dpf_pkg::COORD_W-1:0] cy,
  input  logic [dpf_pkg::R2_W-1:0]    r2,
  output logic                       out_valid,
  output logic [IDX_W-1:0]           out_idx,
  output logic                       out_hit,
  output dpf_pkg::dpf_entry_t        out_entry,
  output logic                       busy
);
  import dpf_pkg::*;

  logic               a_v_r, b_v_r, c_v_r;
  logic [IDX_W-1:0]   a_idx_r, b_idx_r, c_idx_r;
  dpf_entry_t         a_ent_r, b_ent_r, c_ent_r;
  logic [COORD_W-1:0] a_dx_r, a_dy_r;
  logic [R2_W-1:0]    b_sx_r, b_sy_r;
  logic               c_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  // stage a: absolute differences, b: squares, c: sum and compare
  always_ff @(posedge clk) begin
    a_idx_r <= in_idx;
    a_ent_r <= in_entry;
    a_dx_r  <= (cx >= in_entry.x) ? cx - in_entry.x : in_entry.x - cx;
    a_dy_r  <= (cy >= in_entry.y) ? cy - in_entry.y : in_entry.y - cy;
    b_idx_r <= a_idx_r;
    b_ent_r <= a_ent_r;
    b_sx_r  <= R2_W'(a_dx_r) * R2_W'(a_dx_r);
    b_sy_r  <= R2_W'(a_dy_r) * R2_W'(a_dy_r);
    c_idx_r <= b_idx_r;
    c_ent_r <= b_ent_r;
    c_hit_r <= ({1'b0, b_sx_r} + {1'b0, b_sy_r}) <= {1'b0, r2};
  end

  assign out_valid = c_v_r;
  assign out_idx   = c_idx_r;
  assign out_hit   = c_hit_r;
  assign out_entry = c_ent_r;
  assign busy      = a_v_r | b_v_r;

endmodule
`default_nettype wire
